// File: src/artdmx_pkg.sv
// Shared types, constants and helpers for the Art-Net DMX to PWM parser.
// No dependencies; every other file in src/ refers to this package by scoped names.
package artdmx_pkg;

	localparam int PWM_CHANNELS_DEF = 3;
	localparam int DMX_CHANNELS_DEF = 512;
	localparam int CMD_DEPTH        = 2;

	localparam logic [15:0] OPC_POLL   = 16'h2000;
	localparam logic [15:0] OPC_OUTPUT = 16'h5000;

	localparam logic [9:0] ID_LEN          = 10'd8;
	localparam logic [9:0] OPCODE_LO_POS   = 10'd8;
	localparam logic [9:0] OPCODE_HI_POS   = 10'd9;
	localparam logic [9:0] UNIVERSE_OFFSET = 10'd14;
	localparam logic [9:0] DATA_OFFSET     = 10'd18;
	localparam logic [9:0] POS_MAX         = 10'd1023;

	localparam logic [7:0] DUTY_RESET = 8'd64;

	localparam logic KIND_POLL = 1'b0;
	localparam logic KIND_DUTY = 1'b1;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_SUB_NET      = 2'd0;
	localparam reg_idx_t REG_OUT_UNIVERSE = 2'd1;
	localparam reg_idx_t REG_START_ADDR   = 2'd2;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       end_of_packet;
	} item_t;

	typedef struct packed {
		logic       kind;
		logic [3:0] channel_index;
		logic [7:0] duty_value;
		logic       duty_changed;
		logic       restart_pwm;
		logic       last_result;
	} result_t;

	// Packet summary handed from the front end to the command queue.
	typedef struct packed {
		logic push;
		logic poll;
	} cmd_ctrl_t;

	// "Art-Net" followed by a zero byte.
	function automatic logic [7:0] ident_byte(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = 8'h41;
			3'd1: r = 8'h72;
			3'd2: r = 8'h74;
			3'd3: r = 8'h2D;
			3'd4: r = 8'h4E;
			3'd5: r = 8'h65;
			3'd6: r = 8'h74;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// File: src/artdmx_front.sv
// Front end: walks the payload bytes, checks header, opcode and universe, stages DMX data.
// At packet end it issues at most one command for the back end. Depends on artdmx_pkg.
module artdmx_front #(
	parameter int PWM_CHANNELS = artdmx_pkg::PWM_CHANNELS_DEF,
	parameter int DMX_CHANNELS = artdmx_pkg::DMX_CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_vld,
	input  artdmx_pkg::item_t               item,
	input  logic [3:0]                      sub_net,
	input  logic [3:0]                      out_universe,
	input  logic [9:0]                      start_addr,
	output artdmx_pkg::cmd_ctrl_t           cmd_ctrl,
	output logic [PWM_CHANNELS-1:0][7:0]    cmd_duty,
	output logic [PWM_CHANNELS-1:0]         cmd_valid
);

	logic [9:0]                    pos_q;
	logic                          id_ok_q;
	logic [15:0]                   opcode_q;
	logic                          umatch_q;
	logic [PWM_CHANNELS-1:0][7:0]  sduty_q;
	logic [PWM_CHANNELS-1:0]       svld_q;

	logic                          id_ok_n;
	logic [15:0]                   opcode_n;
	logic                          umatch_n;
	logic [PWM_CHANNELS-1:0][7:0]  sduty_n;
	logic [PWM_CHANNELS-1:0]       svld_n;
	logic [9:0]                    pos_n;
	logic                          poll_hit;
	logic                          out_hit;

	always_comb begin
		logic [7:0]  b;
		logic [10:0] addr;
		b        = item.payload_byte;
		addr     = '0;
		id_ok_n  = id_ok_q;
		opcode_n = opcode_q;
		umatch_n = umatch_q;
		sduty_n  = sduty_q;
		svld_n   = svld_q;
		if (pos_q < artdmx_pkg::ID_LEN) begin
			if (b != artdmx_pkg::ident_byte(pos_q[2:0]))
				id_ok_n = 1'b0;
		end else if (pos_q == artdmx_pkg::OPCODE_LO_POS) begin
			opcode_n[7:0] = b;
		end else if (pos_q == artdmx_pkg::OPCODE_HI_POS) begin
			opcode_n[15:8] = b;
		end else if (pos_q == artdmx_pkg::UNIVERSE_OFFSET) begin
			umatch_n = (b == {sub_net, out_universe});
		end else if (pos_q >= artdmx_pkg::DATA_OFFSET) begin
			for (int i = 0; i < PWM_CHANNELS; i++) begin
				addr = {1'b0, start_addr} + 11'(i);
				// DMX address a sits at byte offset 17 + a
				if (addr != 11'd0 && addr <= 11'(DMX_CHANNELS) &&
				    {2'b00, pos_q} == ({1'b0, addr} + 12'(artdmx_pkg::DATA_OFFSET) - 12'd1)) begin
					sduty_n[i] = b;
					svld_n[i]  = 1'b1;
				end
			end
		end
		pos_n    = (pos_q == artdmx_pkg::POS_MAX) ? pos_q : pos_q + 10'd1;
		// count >= 10 means this byte is at offset 9 or later
		poll_hit = id_ok_n && (pos_q >= artdmx_pkg::OPCODE_HI_POS) &&
		           (opcode_n == artdmx_pkg::OPC_POLL);
		out_hit  = id_ok_n && (pos_q >= artdmx_pkg::UNIVERSE_OFFSET) &&
		           (opcode_n == artdmx_pkg::OPC_OUTPUT) && umatch_n;
	end

	assign cmd_ctrl.push = item_vld && item.end_of_packet && (poll_hit || out_hit);
	assign cmd_ctrl.poll = poll_hit;
	assign cmd_duty      = sduty_n;
	assign cmd_valid     = svld_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			id_ok_q  <= 1'b1;
			opcode_q <= '0;
			umatch_q <= 1'b0;
			svld_q   <= '0;
		end else if (item_vld) begin
			if (item.end_of_packet) begin
				pos_q    <= '0;
				id_ok_q  <= 1'b1;
				opcode_q <= '0;
				umatch_q <= 1'b0;
				svld_q   <= '0;
			end else begin
				pos_q    <= pos_n;
				id_ok_q  <= id_ok_n;
				opcode_q <= opcode_n;
				umatch_q <= umatch_n;
				svld_q   <= svld_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_vld)
			sduty_q <= sduty_n;
	end

endmodule

// File: src/artdmx_cmd_fifo.sv
// Small command queue between the packet front end and the duty back end.
// Register based, head read combinationally. Depends on artdmx_pkg for its default depth.
module artdmx_cmd_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = artdmx_pkg::CMD_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         full,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (do_rd)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + CW'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wp_q] <= wr_data;
	end

endmodule

// File: src/artdmx_back.sv
// Back end: executes queued commands, updates the stored PWM duties one channel per cycle
// when the result register is free or popped, and drives the result register. Depends on artdmx_pkg.
module artdmx_back #(
	parameter int PWM_CHANNELS = artdmx_pkg::PWM_CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_empty,
	input  logic                          cmd_poll,
	input  logic [PWM_CHANNELS-1:0][7:0]  cmd_duty,
	input  logic [PWM_CHANNELS-1:0]       cmd_valid,
	output logic                          cmd_pop,
	input  logic                          pop,
	output logic                          empty,
	output artdmx_pkg::result_t           result
);

	localparam int CW = (PWM_CHANNELS > 1) ? $clog2(PWM_CHANNELS) : 1;

	logic                         ovld_q;
	logic [CW-1:0]                ch_q;
	logic                         any_q;
	logic [PWM_CHANNELS-1:0][7:0] duty_q;
	artdmx_pkg::result_t          res_q;

	logic                         load;
	logic [7:0]                   old_duty;
	logic [7:0]                   new_duty;
	logic                         chg;
	logic                         fin;
	logic                         any_n;
	artdmx_pkg::result_t          res_n;

	assign load     = !cmd_empty && (!ovld_q || pop);
	assign old_duty = duty_q[ch_q];
	assign new_duty = cmd_valid[ch_q] ? cmd_duty[ch_q] : old_duty;
	assign chg      = (new_duty != old_duty);
	assign fin      = (ch_q == CW'(PWM_CHANNELS - 1));
	assign any_n    = any_q || chg;
	assign cmd_pop  = load && (cmd_poll || fin);

	always_comb begin
		if (cmd_poll) begin
			res_n.kind          = artdmx_pkg::KIND_POLL;
			res_n.channel_index = '0;
			res_n.duty_value    = '0;
			res_n.duty_changed  = 1'b0;
			res_n.restart_pwm   = 1'b0;
			res_n.last_result   = 1'b1;
		end else begin
			res_n.kind          = artdmx_pkg::KIND_DUTY;
			res_n.channel_index = 4'(ch_q);
			res_n.duty_value    = new_duty;
			res_n.duty_changed  = chg;
			res_n.restart_pwm   = fin && any_n;
			res_n.last_result   = fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
			ch_q   <= '0;
			any_q  <= 1'b0;
			duty_q <= {PWM_CHANNELS{artdmx_pkg::DUTY_RESET}};
		end else begin
			if (load)
				ovld_q <= 1'b1;
			else if (pop)
				ovld_q <= 1'b0;
			if (load && !cmd_poll) begin
				duty_q[ch_q] <= new_duty;
				if (fin) begin
					ch_q  <= '0;
					any_q <= 1'b0;
				end else begin
					ch_q  <= ch_q + CW'(1);
					any_q <= any_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_n;
	end

	assign empty  = !ovld_q;
	assign result = res_q;

endmodule

// File: src/artdmx_pkg_top_placeholder.sv
// Configuration register file for the Art-Net parser (APB write/read decode).
// Depends on artdmx_pkg.
module artdmx_regs (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic [3:0] sub_net,
	output logic [3:0] out_universe,
	output logic [9:0] start_addr
);

	logic [3:0] sub_net_q;
	logic [3:0] out_universe_q;
	logic [9:0] start_addr_q;
	logic       wr;
	artdmx_pkg::reg_idx_t idx;

	assign wr  = psel && penable && pwrite;
	assign idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_net_q      <= 4'd0;
			out_universe_q <= 4'd1;
			start_addr_q   <= 10'd1;
		end else if (wr) begin
			case (idx)
				artdmx_pkg::REG_SUB_NET:      sub_net_q      <= pwdata[3:0];
				artdmx_pkg::REG_OUT_UNIVERSE: out_universe_q <= pwdata[3:0];
				artdmx_pkg::REG_START_ADDR:   start_addr_q   <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			artdmx_pkg::REG_SUB_NET:      prdata = {28'd0, sub_net_q};
			artdmx_pkg::REG_OUT_UNIVERSE: prdata = {28'd0, out_universe_q};
			artdmx_pkg::REG_START_ADDR:   prdata = {22'd0, start_addr_q};
			default:                      prdata = '0;
		endcase
	end

	assign sub_net      = sub_net_q;
	assign out_universe = out_universe_q;
	assign start_addr   = start_addr_q;

endmodule

// File: src/artnet_dmx_to_pwm_parser_core.sv
// Channel   Handshake              Payload
// item      push / full            artdmx_pkg::item_t   (payload_byte, end_of_packet)
// result    pop / empty            artdmx_pkg::result_t (kind .. last_result)
// config    APB psel/penable/...   sub_net @0x0, out_universe @0x4, pwm_start_address @0x8
//
// One payload byte is taken per cycle unless the command queue is full; the front end does a compare
// and a capture per byte. At packet end a command enters a two-entry queue; the back end emits
// one result per cycle when its register is free or popped: PWM_CHANNELS per DMX output, one per poll.
// full rises only while the command queue is full; results drain through one output register.
// Reset is asynchronous, active low, and needs no clearing pass.
module artnet_dmx_to_pwm_parser_core #(
	parameter int PWM_CHANNELS = artdmx_pkg::PWM_CHANNELS_DEF,
	parameter int DMX_CHANNELS = artdmx_pkg::DMX_CHANNELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                push,
	output logic                full,
	input  artdmx_pkg::item_t   item,
	input  logic                pop,
	output logic                empty,
	output artdmx_pkg::result_t result
);

	localparam int CMD_W = 1 + 9 * PWM_CHANNELS;

	logic [3:0]                   sub_net;
	logic [3:0]                   out_universe;
	logic [9:0]                   start_addr;
	logic                         item_vld;
	artdmx_pkg::cmd_ctrl_t        cmd_ctrl;
	logic [PWM_CHANNELS-1:0][7:0] fr_duty;
	logic [PWM_CHANNELS-1:0]      fr_valid;
	logic [CMD_W-1:0]             q_wdata;
	logic [CMD_W-1:0]             q_rdata;
	logic                         q_full;
	logic                         q_empty;
	logic                         q_pop;
	logic                         hd_poll;
	logic [PWM_CHANNELS-1:0][7:0] hd_duty;
	logic [PWM_CHANNELS-1:0]      hd_valid;

	assign pready   = 1'b1;
	assign full     = q_full;
	assign item_vld = push && !q_full;

	artdmx_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.sub_net      (sub_net),
		.out_universe (out_universe),
		.start_addr   (start_addr)
	);

	artdmx_front #(
		.PWM_CHANNELS (PWM_CHANNELS),
		.DMX_CHANNELS (DMX_CHANNELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_vld     (item_vld),
		.item         (item),
		.sub_net      (sub_net),
		.out_universe (out_universe),
		.start_addr   (start_addr),
		.cmd_ctrl     (cmd_ctrl),
		.cmd_duty     (fr_duty),
		.cmd_valid    (fr_valid)
	);

	assign q_wdata = {cmd_ctrl.poll, fr_duty, fr_valid};

	artdmx_cmd_fifo #(
		.W     (CMD_W),
		.DEPTH (artdmx_pkg::CMD_DEPTH)
	) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_ctrl.push),
		.wr_data (q_wdata),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.full    (q_full),
		.empty   (q_empty)
	);

	assign {hd_poll, hd_duty, hd_valid} = q_rdata;

	artdmx_back #(
		.PWM_CHANNELS (PWM_CHANNELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (q_empty),
		.cmd_poll  (hd_poll),
		.cmd_duty  (hd_duty),
		.cmd_valid (hd_valid),
		.cmd_pop   (q_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

`ifndef NO_ASSERTIONS
	// the final duty report of a packet always belongs to the highest channel
	a_last_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == artdmx_pkg::KIND_DUTY && result.last_result) |->
		(result.channel_index == 4'(PWM_CHANNELS - 1)))
		else $error("last duty report not on the highest channel");

	a_restart_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.restart_pwm) |-> result.last_result)
		else $error("restart flag on a non-final result");

	a_poll_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == artdmx_pkg::KIND_POLL) |->
		(result.last_result && result.channel_index == 4'd0 && !result.duty_changed))
		else $error("malformed poll request result");

	// a command is never lost: the front end only issues one while the queue has room
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ctrl.push |-> !q_full)
		else $error("packet command issued into a full queue");
`endif

endmodule

// File: tb/artnet_dmx_to_pwm_parser_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for artnet_dmx_to_pwm_parser_core: Art-Net packets in, PWM reports out.
// Depends on artdmx_pkg for the request/report structs, opcodes and register indexes.
module artnet_dmx_to_pwm_parser_core_test;

	localparam int PWM_N = artdmx_pkg::PWM_CHANNELS_DEF;
	localparam int DMX_N = artdmx_pkg::DMX_CHANNELS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 16;
	localparam int REPORT_MAX = 10;

	localparam logic [63:0] ART_ID = {"Art-Net", 8'h00};
	localparam logic [15:0] OPC_SWAPPED_OUTPUT = 16'h0050;
	localparam logic [15:0] OPC_SWAPPED_POLL   = 16'h0020;
	localparam logic [15:0] OPC_UNKNOWN        = 16'hFFFF;

	typedef enum logic [1:0] {SH_GOOD, SH_BAD_ID, SH_NOISE} pkt_shape_t;
	typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_POLL, EXP_RESET_DUTY} exp_mode_t;

	typedef struct packed {
		pkt_shape_t  shape;
		logic [15:0] opcode;
		logic [10:0] len;
		logic [7:0]  univ;
		logic [7:0]  fill;
		logic        rnd;
		exp_mode_t   exp;
	} dir_row_t;

	localparam artdmx_pkg::result_t POLL_REPLY =
		'{artdmx_pkg::KIND_POLL, 4'd0, 8'd0, 1'b0, 1'b0, 1'b1};
	localparam artdmx_pkg::result_t RESET_DUTY_RPT [3] = '{
		'{artdmx_pkg::KIND_DUTY, 4'd0, 8'd64, 1'b0, 1'b0, 1'b0},
		'{artdmx_pkg::KIND_DUTY, 4'd1, 8'd64, 1'b0, 1'b0, 1'b0},
		'{artdmx_pkg::KIND_DUTY, 4'd2, 8'd64, 1'b0, 1'b0, 1'b1}
	};

	// reset config: subnet 0, universe 1, start address 1 -> channels at offsets 18..20
	localparam dir_row_t DIRECTED_ROWS [24] = '{
		'{SH_GOOD,   artdmx_pkg::OPC_POLL,   11'd10, 8'h00, 8'h00, 1'b0, EXP_POLL},
		'{SH_GOOD,   artdmx_pkg::OPC_POLL,   11'd18, 8'h77, 8'h00, 1'b0, EXP_POLL},
		'{SH_GOOD,   artdmx_pkg::OPC_OUTPUT, 11'd18, 8'h01, 8'h00, 1'b0, EXP_RESET_DUTY},
		'{SH_GOOD,   artdmx_pkg::OPC_OUTPUT, 11'd14, 8'h01, 8'h00, 1'b0, EXP_NONE},
		'{SH_GOOD,   artdmx_pkg::OPC_OUTPUT, 11'd9,  8'h01, 8'h00, 1'b0, EXP_NONE},
		'{SH_GOOD,   artdmx_pkg::OPC_POLL,   11'd9,  8'h00, 8'h00, 1'b0, EXP_NONE},
		'{SH_GOOD,   artdmx_pkg::OPC_OUTPUT, 11'd21, 8'h01, 8'hFF, 1'b0, EXP_MODEL},
		'{SH_GOOD,   artdmx_pkg::OPC_OUTPUT, 11'd21, 8'h01, 8'hFF, 1'b0, EXP_MODEL},
		'{SH_GOOD,   artdmx_pkg::OPC_OUTPUT, 11'd21, 8'h01, 8'h00, 1'b0, EXP_MODEL},
		'{SH_GOOD,   artdmx_pkg::OPC_OUTPUT, 11'd19, 8'h01, 8'h00, 1'b1, EXP_MODEL},
		'{SH_GOOD,   artdmx_pkg::OPC_OUTPUT, 11'd15, 8'h10, 8'hFF, 1'b0, EXP_NONE},
		'{SH_GOOD,   artdmx_pkg::OPC_OUTPUT, 11'd15, 8'h11, 8'hFF, 1'b0, EXP_NONE},
		'{SH_GOOD,   artdmx_pkg::OPC_OUTPUT, 11'd15, 8'hFF, 8'hFF, 1'b0, EXP_NONE},
		'{SH_BAD_ID, artdmx_pkg::OPC_OUTPUT, 11'd15, 8'h01, 8'hAA, 1'b0, EXP_NONE},
		'{SH_BAD_ID, artdmx_pkg::OPC_POLL,   11'd12, 8'h00, 8'h00, 1'b0, EXP_NONE},
		'{SH_GOOD,   OPC_SWAPPED_OUTPUT,     11'd15, 8'h01, 8'h33, 1'b0, EXP_NONE},
		'{SH_GOOD,   OPC_SWAPPED_POLL,       11'd12, 8'h01, 8'h00, 1'b0, EXP_NONE},
		'{SH_GOOD,   OPC_UNKNOWN,            11'd15, 8'h01, 8'h55, 1'b0, EXP_NONE},
		'{SH_NOISE,  OPC_UNKNOWN,            11'd1,  8'h00, 8'h00, 1'b1, EXP_NONE},
		'{SH_GOOD,   artdmx_pkg::OPC_OUTPUT, 11'd26, 8'h01, 8'h00, 1'b1, EXP_MODEL},
		'{SH_GOOD,   artdmx_pkg::OPC_POLL,   11'd12, 8'h01, 8'h00, 1'b0, EXP_POLL},
		'{SH_GOOD,   artdmx_pkg::OPC_OUTPUT, 11'd15, 8'h01, 8'h00, 1'b0, EXP_MODEL},
		'{SH_GOOD,   artdmx_pkg::OPC_OUTPUT, 11'd21, 8'h01, 8'h80, 1'b0, EXP_MODEL},
		'{SH_GOOD,   artdmx_pkg::OPC_OUTPUT, 11'd22, 8'h01, 8'h00, 1'b1, EXP_MODEL}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [3:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                push = 1'b0;
	logic                full;
	artdmx_pkg::item_t   item = '0;
	logic                pop = 1'b0;
	logic                empty;
	artdmx_pkg::result_t result;

	// shadow of the block: registers, per-packet parse state, channel duties
	logic [3:0]  cfg_sub_net = 4'd0;
	logic [3:0]  cfg_universe = 4'd1;
	logic [9:0]  cfg_start = 10'd1;
	logic [9:0]  pkt_pos = '0;
	logic        id_good = 1'b1;
	logic [15:0] pkt_opcode = '0;
	logic        univ_hit = 1'b0;
	logic [7:0]  staged [PWM_N] = '{default: 8'd0};
	logic        staged_ok [PWM_N] = '{default: 1'b0};
	logic [7:0]  duty_now [PWM_N] = '{default: 8'd64};

	artdmx_pkg::result_t step_reports [$];
	artdmx_pkg::result_t expected_reports [$];
	logic [7:0]          pkt_bytes [$];
	artdmx_pkg::result_t want_rpt;
	int          bad_count = 0;
	int          send_idle_pct = 13;
	int          recv_idle_pct = 50;
	int unsigned cycle_count = 0;

	artnet_dmx_to_pwm_parser_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.push    (push),
		.full    (full),
		.item    (item),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Parse one accepted byte; reports caused by it land in step_reports.
	function automatic void decode_payload_byte(input artdmx_pkg::item_t it);
		logic [9:0]          p;
		int                  addr;
		int                  cnt;
		logic                any;
		logic [7:0]          nw;
		artdmx_pkg::result_t r;
		p = pkt_pos;
		step_reports.delete();
		if (p < artdmx_pkg::ID_LEN) begin
			if (it.payload_byte != ART_ID[63 - 8 * int'(p) -: 8])
				id_good = 1'b0;
		end else if (p == artdmx_pkg::OPCODE_LO_POS) begin
			pkt_opcode[7:0] = it.payload_byte;
		end else if (p == artdmx_pkg::OPCODE_HI_POS) begin
			pkt_opcode[15:8] = it.payload_byte;
		end else if (p == artdmx_pkg::UNIVERSE_OFFSET) begin
			univ_hit = (it.payload_byte == {cfg_sub_net, cfg_universe});
		end else if (p >= artdmx_pkg::DATA_OFFSET) begin
			for (int i = 0; i < PWM_N; i++) begin
				addr = int'(cfg_start) + i;
				if (addr >= 1 && addr <= DMX_N &&
				    int'(p) == int'(artdmx_pkg::DATA_OFFSET) - 1 + addr) begin
					staged[i] = it.payload_byte;
					staged_ok[i] = 1'b1;
				end
			end
		end
		if (p < artdmx_pkg::POS_MAX)
			pkt_pos = p + 10'd1;
		if (!it.end_of_packet)
			return;

		cnt = int'(pkt_pos);
		if (id_good && cnt >= 10) begin
			if (pkt_opcode == artdmx_pkg::OPC_POLL) begin
				step_reports.push_back(POLL_REPLY);
			end else if (pkt_opcode == artdmx_pkg::OPC_OUTPUT &&
			             cnt > int'(artdmx_pkg::UNIVERSE_OFFSET) && univ_hit) begin
				any = 1'b0;
				for (int i = 0; i < PWM_N; i++) begin
					nw = staged_ok[i] ? staged[i] : duty_now[i];
					r.kind = artdmx_pkg::KIND_DUTY;
					r.channel_index = 4'(i);
					r.duty_value = nw;
					r.duty_changed = (nw != duty_now[i]);
					any = any | r.duty_changed;
					r.last_result = (i == PWM_N - 1);
					r.restart_pwm = r.last_result & any;
					duty_now[i] = nw;
					step_reports.push_back(r);
				end
			end
		end
		pkt_pos = '0;
		id_good = 1'b1;
		pkt_opcode = '0;
		univ_hit = 1'b0;
		staged_ok = '{default: 1'b0};
	endfunction

	function automatic void build_packet(input pkt_shape_t shape, input logic [15:0] opcode,
			input int len, input logic [7:0] univ, input logic [7:0] fill, input logic rnd);
		logic [7:0] b;
		int         ch;
		int         bad_at;
		pkt_bytes.delete();
		bad_at = $urandom_range(7);
		for (int k = 0; k < len; k++) begin
			if (shape == SH_NOISE) begin
				b = 8'($urandom);
			end else if (k < 8) begin
				b = ART_ID[63 - 8 * k -: 8];
				if (shape == SH_BAD_ID && k == bad_at)
					b = b ^ 8'($urandom_range(255, 1));
			end else if (k == 8) begin
				b = opcode[7:0];
			end else if (k == 9) begin
				b = opcode[15:8];
			end else if (k == int'(artdmx_pkg::UNIVERSE_OFFSET)) begin
				b = univ;
			end else if (k < int'(artdmx_pkg::DATA_OFFSET)) begin
				b = 8'($urandom);
			end else if (rnd) begin
				// now and then repeat the current duty so unchanged channels show up
				ch = k - 17 - int'(cfg_start);
				if (ch >= 0 && ch < PWM_N && $urandom_range(3) == 0)
					b = duty_now[ch];
				else
					b = 8'($urandom);
			end else begin
				b = fill;
			end
			pkt_bytes.push_back(b);
		end
	endfunction

	task automatic feed_byte(input artdmx_pkg::item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic send_packet(input exp_mode_t mode);
		artdmx_pkg::item_t it;
		for (int k = 0; k < pkt_bytes.size(); k++) begin
			it.payload_byte = pkt_bytes[k];
			it.end_of_packet = (k == pkt_bytes.size() - 1);
			feed_byte(it);
			decode_payload_byte(it);
			if (it.end_of_packet && mode != EXP_MODEL) begin
				case (mode)
					EXP_POLL: begin
						expected_reports.push_back(POLL_REPLY);
					end
					EXP_RESET_DUTY: begin
						foreach (RESET_DUTY_RPT[i])
							expected_reports.push_back(RESET_DUTY_RPT[i]);
					end
					default: ;
				endcase
			end else begin
				foreach (step_reports[i])
					expected_reports.push_back(step_reports[i]);
			end
		end
	endtask

	// Let the block drain: every report in, then an idle wait for dropped packets.
	task automatic settle();
		push <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input artdmx_pkg::reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			artdmx_pkg::REG_SUB_NET:      cfg_sub_net = val[3:0];
			artdmx_pkg::REG_OUT_UNIVERSE: cfg_universe = val[3:0];
			artdmx_pkg::REG_START_ADDR:   cfg_start = val[9:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		send_idle_pct = (mode == 0) ? 13 : (mode == 1) ? 50 : 0;
		recv_idle_pct = (mode == 0) ? 50 : (mode == 1) ? 13 : 0;
	endtask

	task automatic run_random_phase(input logic [3:0] sub, input logic [3:0] uni,
			input logic [9:0] start, input int mode);
		int          bytes;
		int          pkts;
		int          r;
		int          q;
		int          len;
		int          base;
		logic [7:0]  univ;
		logic [15:0] opc;
		pkt_shape_t  shape;
		set_idling(mode);
		reg_write(artdmx_pkg::REG_SUB_NET, {28'd0, sub});
		reg_write(artdmx_pkg::REG_OUT_UNIVERSE, {28'd0, uni});
		reg_write(artdmx_pkg::REG_START_ADDR, {22'd0, start});
		bytes = 0;
		pkts = 0;
		while (bytes < 16 || pkts < 2) begin
			r = $urandom_range(99);
			base = 17 + int'(start) + PWM_N;
			univ = ($urandom_range(99) < 85) ? {cfg_sub_net, cfg_universe} : 8'($urandom);
			shape = SH_GOOD;
			opc = artdmx_pkg::OPC_OUTPUT;
			if (r < 15) begin
				opc = artdmx_pkg::OPC_POLL;
				len = $urandom_range(30, 8);
			end else if (r < 70) begin
				q = $urandom_range(99);
				if (q < 60)
					len = base - 2 + $urandom_range(4);
				else if (q < 85)
					len = $urandom_range(24, 10);
				else
					len = $urandom_range(base + 8, 15);
			end else if (r < 80) begin
				shape = SH_BAD_ID;
				opc = $urandom_range(1) ? artdmx_pkg::OPC_POLL : artdmx_pkg::OPC_OUTPUT;
				len = $urandom_range(24, 10);
			end else if (r < 88) begin
				opc = $urandom_range(1) ? OPC_SWAPPED_OUTPUT : 16'($urandom);
				while (opc == artdmx_pkg::OPC_POLL || opc == artdmx_pkg::OPC_OUTPUT)
					opc = 16'($urandom);
				len = $urandom_range(24, 10);
			end else begin
				shape = SH_NOISE;
				len = $urandom_range(24, 1);
			end
			build_packet(shape, opc, len, univ, 8'h00, 1'b1);
			send_packet(EXP_MODEL);
			bytes += len;
			pkts++;
		end
		settle();
	endtask

	always @(posedge clk) begin
		pop <= arst_n && ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && pop && !empty) begin
			if (expected_reports.size() == 0) begin
				if (bad_count < REPORT_MAX)
					$display("unexpected report: kind=%0d ch=%0d duty=%0d chg=%0d rst=%0d last=%0d",
						result.kind, result.channel_index, result.duty_value,
						result.duty_changed, result.restart_pwm, result.last_result);
				bad_count++;
			end else begin
				want_rpt = expected_reports.pop_front();
				if (result.kind !== want_rpt.kind ||
						result.channel_index !== want_rpt.channel_index ||
						result.duty_value !== want_rpt.duty_value ||
						result.duty_changed !== want_rpt.duty_changed ||
						result.restart_pwm !== want_rpt.restart_pwm ||
						result.last_result !== want_rpt.last_result) begin
					if (bad_count < REPORT_MAX) begin
						$display("report mismatch at %0t", $realtime);
						$display("  exp kind=%0d ch=%0d duty=%0d chg=%0d rst=%0d last=%0d",
							want_rpt.kind, want_rpt.channel_index, want_rpt.duty_value,
							want_rpt.duty_changed, want_rpt.restart_pwm, want_rpt.last_result);
						$display("  got kind=%0d ch=%0d duty=%0d chg=%0d rst=%0d last=%0d",
							result.kind, result.channel_index, result.duty_value,
							result.duty_changed, result.restart_pwm, result.last_result);
					end
					bad_count++;
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(0);
		foreach (DIRECTED_ROWS[i]) begin
			build_packet(DIRECTED_ROWS[i].shape, DIRECTED_ROWS[i].opcode,
				int'(DIRECTED_ROWS[i].len), DIRECTED_ROWS[i].univ,
				DIRECTED_ROWS[i].fill, DIRECTED_ROWS[i].rnd);
			send_packet(DIRECTED_ROWS[i].exp);
		end
		settle();

		run_random_phase(4'hF, 4'hF, 10'd1, 0);
		// address zero is never captured, so channel 0 keeps its duty
		run_random_phase(4'h5, 4'hA, 10'd0, 1);
		run_random_phase(4'($urandom), 4'($urandom), 10'($urandom_range(8, 1)), 2);

		if (bad_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
